[rtl/core/rctpg_pkg.sv]
// ----------------------------------------------------------------------------
// rctpg_pkg
// Shared types and constants for the RC toy pulse-code generator.
// ----------------------------------------------------------------------------
package rctpg_pkg;

    // Input kind carried on tuser
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Field and state widths
    localparam int CMD_W      = 9;
    localparam int LEN_W      = 10;
    localparam int REP_W      = 8;
    localparam int QUOT_W     = 7;
    localparam int DIVR_W     = 10;
    localparam int STEP_W     = 3;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 8;

    // Repeat count numerator and its restoring-divide length
    localparam logic [QUOT_W-1:0] REPEAT_BASE = 7'd100;
    localparam logic [STEP_W-1:0] DIV_LAST    = 3'd6;

    // Longest frame the length register can hold
    localparam logic [LEN_W-1:0] FRAME_LIMIT = 10'd1023;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic apply;
    } rctpg_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic frame_start;
        logic div_last;
    } rctpg_sts_t;

endpackage

[rtl/core/rc_toy_pulse_code_generator.sv]
// ----------------------------------------------------------------------------
// rc_toy_pulse_code_generator
// Toy radio-control pulse encoder: command writes and half-period ticks in,
// one status word per input word out.
// ----------------------------------------------------------------------------
// Each input word gives exactly one output word. A command write, or a tick
// that does not open a frame, passes through the decide and apply states
// after it is accepted, and its output word is loaded in apply. A tick that
// opens a frame also passes through the divide state between them, because
// the repeat count 100/(count + 2*START_CODES) comes from a restoring divider
// that resolves one quotient bit per cycle. One word is in work at a time;
// the next word is accepted in the cycle after a result is loaded, even
// while that result still waits in the output register. The line level
// holds while no frame is being sent.
module rc_toy_pulse_code_generator
#(
    parameter int START_CODES = 4,
    parameter int MAX_PULSES  = 128
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rctpg_pkg::S_TDATA_W-1:0] s_tdata,   // [8:0] command, rest zero
    input  logic                            s_tuser,   // [0] func: 0 tick, 1 write
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rctpg_pkg::M_TDATA_W-1:0] m_tdata    // [0] line_level, [1] sending,
                                                       // [2] rejected, rest zero
);
    import rctpg_pkg::*;

    rctpg_cmd_t cmd;
    rctpg_sts_t sts;

    // Sequencing and handshake
    rctpg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Frame state, divider and output register
    rctpg_dp
    #(
        .START_CODES (START_CODES),
        .MAX_PULSES  (MAX_PULSES)
    )
    u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

[rtl/core/rctpg_ctrl.sv]
// ----------------------------------------------------------------------------
// rctpg_ctrl
// Controller: sequences one word through decode, repeat divide and update,
// and owns the output valid flag.
// ----------------------------------------------------------------------------
module rctpg_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  rctpg_pkg::rctpg_sts_t sts,
    output rctpg_pkg::rctpg_cmd_t cmd
);
    import rctpg_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DECIDE = 4'b0010,
        ST_DIV    = 4'b0100,
        ST_APPLY  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    // The output register can take a new word when empty or being drained.
    assign slot_free = !out_valid_reg || m_tready;

    // Next state and command decode
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (sts.frame_start)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (slot_free)
                begin
                    cmd.apply  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set when a result is written, cleared when taken.
    always_comb
    begin
        if (cmd.apply)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

[rtl/core/rctpg_dp.sv]
// ----------------------------------------------------------------------------
// rctpg_dp
// Datapath: input latch, frame state, restoring divider for the repeat
// count, pattern generation and the output register.
// ----------------------------------------------------------------------------
module rctpg_dp
#(
    parameter int START_CODES = 4,
    parameter int MAX_PULSES  = 128
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [rctpg_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    output logic [rctpg_pkg::M_TDATA_W-1:0] m_tdata,
    input  rctpg_pkg::rctpg_cmd_t         cmd,
    output rctpg_pkg::rctpg_sts_t         sts
);
    import rctpg_pkg::*;

    localparam logic [LEN_W:0]    START_LEN = (LEN_W+1)'(START_CODES * 4);
    localparam logic [LEN_W-1:0]  START_END = LEN_W'(START_CODES * 4);
    localparam logic [DIVR_W-1:0] DIV_BIAS  = DIVR_W'(START_CODES * 2);
    localparam logic [CMD_W:0]    CMD_MAX   = (CMD_W+1)'(MAX_PULSES * 2);

    // Latched input word
    logic              func_reg;
    logic [CMD_W-1:0]  cmd_reg;

    // Frame state
    logic [CMD_W-1:0]  pending_reg,  pending_next;
    logic [LEN_W-1:0]  flen_reg,     flen_next;
    logic [LEN_W-1:0]  pos_reg,      pos_next;
    logic [REP_W-1:0]  rep_reg,      rep_next;
    logic              level_reg,    level_next;

    // Divider
    logic [DIVR_W-1:0] divisor_reg;
    logic [DIVR_W-1:0] rem_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DIVR_W:0]   trial;
    logic              trial_ge;

    // Output register
    logic              out_level_reg;
    logic              out_sending_reg;
    logic              out_rejected_reg;

    // Update helpers
    logic              frame_start;
    logic [LEN_W:0]    len_raw;
    logic [LEN_W-1:0]  len_sat;
    logic [LEN_W-1:0]  flen_eff;
    logic [LEN_W-1:0]  pos_eff;
    logic [REP_W-1:0]  rep_eff;
    logic [LEN_W-1:0]  pos_inc;
    logic              pat_bit;
    logic              reject;

    // A tick starts a frame when a command waits and nothing is being sent.
    assign frame_start = (func_reg == FUNC_TICK) && (pending_reg != '0) && (flen_reg == '0);

    assign sts.frame_start = frame_start;
    assign sts.div_last    = (step_reg == DIV_LAST);

    // Frame length with saturation
    assign len_raw = {1'b0, pending_reg, 1'b0} + START_LEN;
    assign len_sat = (len_raw > {1'b0, FRAME_LIMIT}) ? FRAME_LIMIT : len_raw[LEN_W-1:0];

    // One restoring-divide step
    assign trial    = {rem_reg, quot_reg[QUOT_W-1]};
    assign trial_ge = (trial >= {1'b0, divisor_reg});

    // Input latch and divider registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= s_tuser;
            cmd_reg  <= s_tdata[CMD_W-1:0];
        end
        if (cmd.div_start)
        begin
            divisor_reg <= {1'b0, pending_reg} + DIV_BIAS;
            rem_reg     <= '0;
            quot_reg    <= REPEAT_BASE;
            step_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            if (trial_ge)
            begin
                rem_reg <= DIVR_W'(trial - {1'b0, divisor_reg});
            end
            else
            begin
                rem_reg <= trial[DIVR_W-1:0];
            end
            quot_reg <= {quot_reg[QUOT_W-2:0], trial_ge};
            step_reg <= step_reg + 1'b1;
        end
    end

    // Values seen by this tick, after a possible frame start
    assign flen_eff = frame_start ? len_sat : flen_reg;
    assign pos_eff  = frame_start ? '0 : pos_reg;
    assign rep_eff  = frame_start ? {1'b0, quot_reg} : rep_reg;
    assign pos_inc  = pos_eff + 1'b1;

    // Start codes send 0,0,0,1; the body alternates 0,1.
    assign pat_bit = (pos_eff < START_END) ? (pos_eff[1:0] == 2'b11) : pos_eff[0];

    assign reject = (func_reg == FUNC_WRITE) && ({1'b0, cmd_reg} > CMD_MAX);

    // Next frame state for the current word
    always_comb
    begin
        pending_next = pending_reg;
        flen_next    = flen_reg;
        pos_next     = pos_reg;
        rep_next     = rep_reg;
        level_next   = level_reg;
        if (func_reg == FUNC_WRITE)
        begin
            if (!reject)
            begin
                pending_next = cmd_reg;
            end
        end
        else
        begin
            if (frame_start)
            begin
                pending_next = '0;
            end
            flen_next = flen_eff;
            pos_next  = pos_eff;
            rep_next  = rep_eff;
            if (flen_eff != '0)
            begin
                level_next = pat_bit;
                if (pos_inc >= flen_eff)
                begin
                    pos_next = '0;
                    if (rep_eff <= REP_W'(1))
                    begin
                        rep_next  = '0;
                        flen_next = '0;
                    end
                    else
                    begin
                        rep_next = rep_eff - 1'b1;
                    end
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end
        end
    end

    // Frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            flen_reg    <= '0;
            pos_reg     <= '0;
            rep_reg     <= '0;
            level_reg   <= 1'b0;
        end
        else if (cmd.apply)
        begin
            pending_reg <= pending_next;
            flen_reg    <= flen_next;
            pos_reg     <= pos_next;
            rep_reg     <= rep_next;
            level_reg   <= level_next;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            out_level_reg    <= level_next;
            out_sending_reg  <= (flen_next != '0);
            out_rejected_reg <= reject;
        end
    end

    assign m_tdata = {{(M_TDATA_W-3){1'b0}}, out_rejected_reg, out_sending_reg, out_level_reg};

endmodule

[rtl/core/rctpg_checker.sv]
// ----------------------------------------------------------------------------
// rctpg_checker
// Port-level checks for the RC toy pulse-code generator, bound to the top.
// ----------------------------------------------------------------------------
module rctpg_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // A stalled output word holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // Only one word is in work: ready drops right after an accept.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice without a result in between");

    // A new output word appears only as the word in work completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("output word appeared while the block was idle");

    // Ready only falls because a word was accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid))
        else $error("input ready dropped without an accepted word");

endmodule

bind rc_toy_pulse_code_generator rctpg_checker u_rctpg_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
